FILE: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // Result beat: removed key, top key, entry count, padded to whole bytes.
    localparam int OUT_BITS   = 2 * KEY_BITS + COUNT_BITS;
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
    localparam int OUT_W      = 8 * OUT_BYTES;
    localparam int IN_W       = 8 * ((KEY_BITS + 7) / 8);

    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic [COUNT_BITS-1:0]      count_t;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_UNUSED     = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic ext;
        key_t key;
    } cell_cmd_t;

endpackage

FILE: rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Priority queue of signed keys returning the maximum, built as a sorted
// chain of cells.
// ----------------------------------------------------------------------------
// Every input beat is one operation and yields exactly one result beat,
// registered in the cycle after it is accepted. The keys live in a row of
// CAPACITY cells kept in descending order, cell 0 holding the maximum. An
// insert compares the new key against every cell at once; each cell either
// keeps its key, takes the new key, or takes its upper neighbor's key, so the
// key drops into place. An extract shifts every cell one place toward the
// head. The work of an operation is one signed compare per cell plus a
// select; a new beat is taken in every cycle in which the result register
// is empty or being drained. The result carries the removed key (zero unless
// an extract succeeded), the largest key after the operation (zero when
// empty), the count and a status: an insert into a full queue and an extract
// from an empty queue leave the contents unchanged and are flagged. Slots
// beyond the count hold stale data and are never shown.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Input beat.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // key_in
    input  logic             s_tuser,   // opcode
    // Result beat.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // removed_key, top_key, entry_count
    output logic [1:0]       m_tuser    // status
);

    count_t            count_reg;
    count_t            count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;
    status_t           out_status_reg;
    status_t           out_status_next;

    logic              accept;
    opcode_t           op;
    key_t              key_in;
    logic              full;
    logic              empty;
    cell_cmd_t         cmd;
    status_t           status;
    key_t              removed_key;
    key_t              top_key;

    key_t              cell_key  [CAPACITY];
    logic              cell_take [CAPACITY];

    // The result register frees up when its beat is taken downstream.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser);
    assign key_in   = key_t'(s_tdata[KEY_BITS-1:0]);
    assign full     = (count_reg == count_t'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb begin
        cmd.key = key_in;
        cmd.ins = accept && (op == OP_INSERT) && !full;
        cmd.ext = accept && (op == OP_EXTRACT) && !empty;
    end

    // Row of cells: cell 0 is the head, data moves one slot per operation.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic slot_valid;
        logic prev_take;
        key_t prev_key;
        key_t next_key;

        assign slot_valid = (count_reg > count_t'(i));

        if (i == 0) begin : g_head
            assign prev_take = 1'b0;
            assign prev_key  = key_in;
        end else begin : g_body
            assign prev_take = cell_take[i-1];
            assign prev_key  = cell_key[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_key = cell_key[i];
        end else begin : g_inner
            assign next_key = cell_key[i+1];
        end

        mhpq_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .slot_valid (slot_valid),
            .prev_take  (prev_take),
            .prev_key   (prev_key),
            .next_key   (next_key),
            .take       (cell_take[i]),
            .key        (cell_key[i])
        );
    end

    // Result of the operation, formed from the values the cells will load.
    always_comb begin
        count_next  = count_reg;
        status      = ST_OK;
        removed_key = '0;
        if (accept) begin
            if (op == OP_INSERT) begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    count_next = count_reg + count_t'(1);
                end
            end else begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    count_next  = count_reg - count_t'(1);
                    removed_key = cell_key[0];
                end
            end
        end

        if (count_next == '0) begin
            top_key = '0;
        end else if (cmd.ins) begin
            top_key = cell_take[0] ? key_in : cell_key[0];
        end else if (cmd.ext) begin
            top_key = cell_key[1];
        end else begin
            top_key = cell_key[0];
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            out_valid_next  = 1'b1;
            out_data_next   = '0;
            out_data_next[KEY_BITS-1:0]            = removed_key;
            out_data_next[2*KEY_BITS-1:KEY_BITS]   = top_key;
            out_data_next[OUT_BITS-1:2*KEY_BITS]   = count_next;
            out_status_next = status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

FILE: rtl/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted key chain; shifts toward or away from the head.
// ----------------------------------------------------------------------------
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      slot_valid,
    input  logic      prev_take,
    input  key_t      prev_key,
    input  key_t      next_key,
    output logic      take,
    output key_t      key
);

    key_t key_reg;
    key_t key_next;

    // A slot yields to the new key when it is empty or holds a smaller key.
    assign take = !slot_valid || (cmd.key > key_reg);
    assign key  = key_reg;

    always_comb begin
        key_next = key_reg;
        if (cmd.ins) begin
            if (take) begin
                key_next = prev_take ? prev_key : cmd.key;
            end
        end else if (cmd.ext) begin
            key_next = next_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule
